// ===== hw/rtl/lcdnf_pkg.sv =====
// Shared types, sizes and codes of the character-LCD number formatter.
// Depends on nothing; every RTL file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package lcdnf_pkg;

    // sizes
    localparam int MAX_DIGITS   = 16;
    localparam int VALUE_BITS   = 16;
    // decimal places a VALUE_BITS magnitude can fill (log10(2) ~ 0.30103)
    localparam int BCD_DIGITS   = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int STORE_DIGITS = (MAX_DIGITS > BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
    localparam int PLACE_W      = (STORE_DIGITS > 1) ? $clog2(STORE_DIGITS) : 1;
    localparam int COUNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int CONV_W       = $clog2(VALUE_BITS + 1);

    // request codes
    localparam logic [2:0] CMD_CHAR = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_SDEC = 3'd2;
    localparam logic [2:0] CMD_HEX  = 3'd3;
    localparam logic [2:0] CMD_BIN  = 3'd4;

    // bus bytes
    localparam logic [7:0] ADDR_CMD    = 8'h80;
    localparam logic [7:0] LINE2_OFS   = 8'h40;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_A     = 8'h41;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    // one display request
    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  line;
        logic [4:0]  column;
        logic [15:0] value;
        logic [4:0]  digit_count;
        logic [7:0]  char_code;
    } req_t;

    // one bus write
    typedef struct packed {
        logic       register_select;
        logic [7:0] bus_byte;
        logic       last_write;
    } res_t;

    // sequencer to digit unit
    typedef struct packed {
        logic load;
        logic shift;
    } dig_ctrl_t;

    // digit value to character code, upper-case hex letters
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] wide;
        wide = {4'b0000, d};
        if (d < 4'd10)
            return ASCII_ZERO + wide;
        else
            return ASCII_A + wide - 8'd10;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcdnf_digit_unit.sv =====
// Digit store of the formatter: loads hex/binary places directly and builds
// decimal places bit-serially (shift-and-add-3). Depends on lcdnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdnf_digit_unit (
    input  wire                         clk,
    input  wire  lcdnf_pkg::dig_ctrl_t  ctrl,
    input  wire  [2:0]                  command,
    input  wire  [15:0]                 value,
    input  wire  [lcdnf_pkg::PLACE_W-1:0] place,
    output logic [3:0]                  digit
);
    import lcdnf_pkg::*;

    localparam int HEX_W = STORE_DIGITS * 4;
    localparam int BCD_W = BCD_DIGITS * 4;

    logic [3:0]            dig_reg [STORE_DIGITS];
    logic [3:0]            dig_next [STORE_DIGITS];
    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;

    logic [VALUE_BITS-1:0] vbits;
    logic                  negative;
    logic [HEX_W-1:0]      hex_flat;
    logic [STORE_DIGITS-1:0] bin_flat;
    logic [BCD_W-1:0]      bcd_adj;
    logic [BCD_W-1:0]      bcd_shifted;

    // value masked to its working width, its sign, and its hex and binary places
    assign vbits    = VALUE_BITS'(value);
    assign negative = (command == CMD_SDEC) && vbits[VALUE_BITS-1];
    assign hex_flat = HEX_W'(vbits);
    assign bin_flat = STORE_DIGITS'(vbits);

    // add-3 correction on each decimal place, then shift one bit in
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (dig_reg[i] >= 4'd5)
                bcd_adj[i*4 +: 4] = dig_reg[i] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = dig_reg[i];
        end
        bcd_shifted = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
    end

    // next contents of the digit store and magnitude shifter
    always_comb
    begin
        dig_next = dig_reg;
        mag_next = mag_reg;
        if (ctrl.load)
        begin
            mag_next = negative ? (~vbits + 1'b1) : vbits;
            for (int p = 0; p < STORE_DIGITS; p++)
            begin
                case (command) inside
                    CMD_HEX: dig_next[p] = hex_flat[p*4 +: 4];
                    CMD_BIN: dig_next[p] = {3'b000, bin_flat[p]};
                    default: dig_next[p] = 4'd0;
                endcase
            end
        end
        else if (ctrl.shift)
        begin
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            for (int i = 0; i < BCD_DIGITS; i++)
                dig_next[i] = bcd_shifted[i*4 +: 4];
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        mag_reg <= mag_next;
    end

    assign digit = dig_reg[place];

endmodule

`default_nettype wire

// ===== hw/rtl/lcd_number_formatter_top.sv =====
// Character-LCD number formatter: request sequencer and bus-write output.
// Depends on lcdnf_pkg and lcdnf_digit_unit.
//
// Usage:
//   A request transfer happens at a rising edge with start high and busy low;
//   the fields come on request. Busy rises in the next cycle and stays high
//   until the last write of the request has been issued.
//   Each bus write appears on result for exactly one cycle with strobe high.
//   First comes the set-address write, then char, sign and digit writes,
//   one per cycle outside decimal conversion; last_write marks the last.
//   The receiver cannot stall: every strobe cycle is a transfer.
// Write order:
//   The address write is registered in state S_ADDR, after the transfer.
//   Char, hex and binary writes follow it back to back.
//   Decimal requests first run the shift-and-add-3 converter one value bit
//   per cycle, between the address (and sign) write and the digit writes;
//   with no digits the request ends right after its address (and sign)
//   write.
//   The last write is on the result ports in the cycle busy falls, so the
//   next request may be taken at that edge.
// Reset:
//   rst_n clears the sequencer and the strobe; no write is pending after it.
`timescale 1ns / 1ps
`default_nettype none

module lcd_number_formatter_top (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire  lcdnf_pkg::req_t request,
    output logic               busy,
    output logic               strobe,
    output lcdnf_pkg::res_t    result
);
    import lcdnf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADDR  = 6'b000010,
        S_CHAR  = 6'b000100,
        S_SIGN  = 6'b001000,
        S_CONV  = 6'b010000,
        S_DIGIT = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic                strobe_reg, strobe_next;
    res_t                result_reg, result_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  place_reg, place_next;
    logic [CONV_W-1:0]   conv_reg, conv_next;
    logic [7:0]          addr_reg, addr_next;
    logic [7:0]          chr_reg, chr_next;
    logic                neg_reg, neg_next;

    dig_ctrl_t           dig_ctrl;
    logic [COUNT_W-1:0]  place_dec;
    logic [PLACE_W-1:0]  place_idx;
    logic [3:0]          digit;
    logic [VALUE_BITS-1:0] req_vbits;
    logic [7:0]          col_ofs;

    // shared digit store and decimal converter
    lcdnf_digit_unit u_digit (
        .clk     (clk),
        .ctrl    (dig_ctrl),
        .command (request.command),
        .value   (request.value),
        .place   (place_idx),
        .digit   (digit)
    );

    assign place_dec = place_reg - 1'b1;
    assign place_idx = PLACE_W'(place_dec);
    assign req_vbits = VALUE_BITS'(request.value);
    assign col_ofs   = {3'b000, request.column} - 8'd1;

    // request sequencer
    always_comb
    begin
        state_next    = state_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        place_next    = place_reg;
        conv_next     = conv_reg;
        addr_next     = addr_reg;
        chr_next      = chr_reg;
        neg_next      = neg_reg;
        dig_ctrl      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = request.command;
                    if (request.digit_count > 5'(MAX_DIGITS))
                        count_next = COUNT_W'(MAX_DIGITS);
                    else
                        count_next = COUNT_W'(request.digit_count);
                    if (request.line == 2'd1)
                        addr_next = ADDR_CMD | col_ofs;
                    else
                        addr_next = ADDR_CMD | (col_ofs + LINE2_OFS);
                    chr_next      = request.char_code;
                    neg_next      = req_vbits[VALUE_BITS-1];
                    dig_ctrl.load = 1'b1;
                    state_next    = S_ADDR;
                end
            end
            S_ADDR:
            begin
                strobe_next                 = 1'b1;
                result_next.register_select = 1'b0;
                result_next.bus_byte        = addr_reg;
                place_next                  = count_reg;
                conv_next                   = CONV_W'(VALUE_BITS);
                case (cmd_reg) inside
                    CMD_CHAR:
                    begin
                        result_next.last_write = 1'b0;
                        state_next             = S_CHAR;
                    end
                    CMD_SDEC:
                    begin
                        result_next.last_write = 1'b0;
                        state_next             = S_SIGN;
                    end
                    CMD_UDEC:
                    begin
                        result_next.last_write = (count_reg == '0);
                        state_next = (count_reg == '0) ? S_IDLE : S_CONV;
                    end
                    CMD_HEX, CMD_BIN:
                    begin
                        result_next.last_write = (count_reg == '0);
                        state_next = (count_reg == '0) ? S_IDLE : S_DIGIT;
                    end
                    default:
                    begin
                        result_next.last_write = 1'b1;
                        state_next             = S_IDLE;
                    end
                endcase
            end
            S_CHAR:
            begin
                strobe_next = 1'b1;
                result_next = '{register_select: 1'b1, bus_byte: chr_reg, last_write: 1'b1};
                state_next  = S_IDLE;
            end
            S_SIGN:
            begin
                strobe_next                 = 1'b1;
                result_next.register_select = 1'b1;
                result_next.bus_byte        = neg_reg ? ASCII_MINUS : ASCII_PLUS;
                result_next.last_write      = (count_reg == '0);
                state_next = (count_reg == '0) ? S_IDLE : S_CONV;
            end
            S_CONV:
            begin
                // one value bit into the decimal places per cycle
                dig_ctrl.shift = 1'b1;
                conv_next      = conv_reg - 1'b1;
                if (conv_reg == CONV_W'(1))
                    state_next = S_DIGIT;
            end
            S_DIGIT:
            begin
                strobe_next                 = 1'b1;
                result_next.register_select = 1'b1;
                result_next.bus_byte        = digit_char(digit);
                result_next.last_write      = (place_reg == COUNT_W'(1));
                place_next                  = place_dec;
                if (place_reg == COUNT_W'(1))
                    state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        cmd_reg    <= cmd_next;
        count_reg  <= count_next;
        place_reg  <= place_next;
        conv_reg   <= conv_next;
        addr_reg   <= addr_next;
        chr_reg    <= chr_next;
        neg_reg    <= neg_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== test/lcd_number_formatter_top_test.sv =====
// Self-checking testbench of lcd_number_formatter_top: directed and random display requests,
// each predicted here as its run of bus writes and checked write by write.
// Depends on lcdnf_pkg and the RTL of lcd_number_formatter_top.
`timescale 1ns / 1ps

module lcd_number_formatter_top_test;
    import lcdnf_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 236;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int CMD_CODES    = 8;

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic start   = 1'b0;
    req_t request = '0;
    logic busy;
    logic strobe;
    res_t result;

    // requests waiting to be sent, bus writes waiting to be seen
    req_t requests_pending [$];
    res_t bus_writes_due [$];

    int gap_left       = 0;
    int burst_left     = 0;
    int cycle_count    = 0;
    int errors         = 0;
    int requests_sent  = 0;
    int writes_checked = 0;
    int directed_items = 0;
    int cmd_seen [CMD_CODES] = '{default: 0};

    lcd_number_formatter_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .strobe  (strobe),
        .result  (result)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // expected bus writes of one request: address, then char, sign and digits
    task automatic predict_writes(input req_t r);
        res_t            seq [0:MAX_DIGITS + 1];
        int              n;
        int              places;
        int unsigned     radix;
        logic [15:0]     mag;
        logic [7:0]      col_ofs;
        logic [7:0]      digit;
        longint unsigned wide;
        longint unsigned scale;
        n      = 0;
        places = (r.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(r.digit_count);
        radix  = 10;
        mag    = r.value;
        // column counted from one, wraps at zero
        col_ofs = {3'b000, r.column} - 8'd1;
        if (r.line != 2'd1)
            col_ofs = col_ofs + LINE2_OFS;
        seq[n] = '{1'b0, ADDR_CMD | col_ofs, 1'b0};
        n++;
        case (r.command)
            CMD_CHAR:
            begin
                seq[n] = '{1'b1, r.char_code, 1'b0};
                n++;
                places = 0;
            end
            CMD_UDEC:
                radix = 10;
            CMD_SDEC:
            begin
                if (mag[VALUE_BITS - 1])
                begin
                    mag = ~mag + 16'd1;
                    if (mag == 16'd0)
                        mag = 16'h8000;
                    seq[n] = '{1'b1, ASCII_MINUS, 1'b0};
                end
                else
                begin
                    seq[n] = '{1'b1, ASCII_PLUS, 1'b0};
                end
                n++;
            end
            CMD_HEX:
                radix = 16;
            CMD_BIN:
                radix = 2;
            default:
                places = 0;
        endcase
        // digit places, most significant first
        wide = 64'(mag);
        for (int k = places - 1; k >= 0; k--)
        begin
            if (radix == 16)
                digit = 8'((wide >> (4 * k)) & 64'hF);
            else if (radix == 2)
                digit = 8'((wide >> k) & 64'h1);
            else
            begin
                scale = 1;
                for (int j = 0; j < k; j++)
                    scale = scale * 10;
                digit = 8'((wide / scale) % 10);
            end
            seq[n] = '{1'b1, (digit < 8'd10) ? ASCII_ZERO + digit : ASCII_A + digit - 8'd10,
                       1'b0};
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            seq[i].last_write = (i == n - 1);
            bus_writes_due.push_back(seq[i]);
        end
    endtask

    task automatic add_request(input logic [2:0] cmd, input logic [1:0] ln,
                               input logic [4:0] col, input logic [15:0] val,
                               input logic [4:0] cnt, input logic [7:0] chr);
        req_t item;
        item.command     = cmd;
        item.line        = ln;
        item.column      = col;
        item.value       = val;
        item.digit_count = cnt;
        item.char_code   = chr;
        requests_pending.push_back(item);
    endtask

    // request driver: one transfer per start high with busy low, random gaps between
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic next_start;
        req_t next_req;
        logic free;
        int   pick;
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            next_start = start;
            next_req   = request;
            free       = !start;
            if (start && !busy)
            begin
                predict_writes(request);
                requests_sent++;
                cmd_seen[request.command]++;
                free       = 1'b1;
                next_start = 1'b0;
            end
            if (free)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (requests_pending.size() > 0)
                begin
                    next_req   = requests_pending.pop_front();
                    next_start = 1'b1;
                    // idle time after this request: mostly short, some long, some bursts
                    pick = $urandom_range(0, 99);
                    if (burst_left > 0)
                    begin
                        burst_left--;
                        gap_left = 0;
                    end
                    else if (pick < 4)
                    begin
                        burst_left = $urandom_range(10, 30);
                        gap_left   = 0;
                    end
                    else if (pick < 55)
                        gap_left = 0;
                    else if (pick < 88)
                        gap_left = $urandom_range(1, 4);
                    else
                        gap_left = $urandom_range(8, 45);
                end
            end
            start   <= next_start;
            request <= next_req;
        end
    end

    // write monitor: every strobe cycle is one transfer
    always @(posedge clk)
    begin : monitor
        res_t want;
        if (rst_n && strobe)
        begin
            if (bus_writes_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected bus write, actual rs=%0b byte=%02h last=%0b",
                         $time, result.register_select, result.bus_byte, result.last_write);
            end
            else
            begin
                want = bus_writes_due.pop_front();
                writes_checked++;
                if (result.register_select !== want.register_select)
                begin
                    errors++;
                    $display("%0t: register_select expected %0b actual %0b",
                             $time, want.register_select, result.register_select);
                end
                if (result.bus_byte !== want.bus_byte)
                begin
                    errors++;
                    $display("%0t: bus_byte expected %02h actual %02h",
                             $time, want.bus_byte, result.bus_byte);
                end
                if (result.last_write !== want.last_write)
                begin
                    errors++;
                    $display("%0t: last_write expected %0b actual %0b",
                             $time, want.last_write, result.last_write);
                end
            end
        end
    end

    // run time limit
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout with %0d bus writes outstanding", $time, bus_writes_due.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        req_t item;
        int   vsel;
        // field extremes, every command, wrap and saturation cases
        add_request(CMD_CHAR, 2'd1, 5'd1, 16'h0000, 5'd0, 8'h00);
        add_request(CMD_CHAR, 2'd2, 5'd16, 16'hFFFF, 5'd31, 8'hFF);
        add_request(CMD_UDEC, 2'd1, 5'd1, 16'h0000, 5'd5, 8'h00);
        add_request(CMD_UDEC, 2'd2, 5'd16, 16'hFFFF, 5'd16, 8'hFF);
        add_request(CMD_UDEC, 2'd1, 5'd4, 16'd12345, 5'd3, 8'h5A);
        add_request(CMD_UDEC, 2'd2, 5'd2, 16'hFFFF, 5'd17, 8'hA5);
        add_request(CMD_UDEC, 2'd1, 5'd9, 16'd9, 5'd1, 8'h00);
        add_request(CMD_SDEC, 2'd1, 5'd1, 16'h8000, 5'd5, 8'h00);
        add_request(CMD_SDEC, 2'd2, 5'd3, 16'h7FFF, 5'd5, 8'h00);
        add_request(CMD_SDEC, 2'd1, 5'd7, 16'hFFFF, 5'd1, 8'h00);
        add_request(CMD_SDEC, 2'd2, 5'd8, 16'h0000, 5'd0, 8'h00);
        add_request(CMD_SDEC, 2'd1, 5'd5, 16'h8001, 5'd16, 8'h00);
        add_request(CMD_HEX, 2'd1, 5'd12, 16'hABCD, 5'd4, 8'h00);
        add_request(CMD_HEX, 2'd2, 5'd1, 16'hFFFF, 5'd16, 8'h00);
        add_request(CMD_HEX, 2'd1, 5'd1, 16'h0000, 5'd0, 8'h00);
        add_request(CMD_BIN, 2'd2, 5'd1, 16'hAAAA, 5'd16, 8'h00);
        add_request(CMD_BIN, 2'd1, 5'd1, 16'h5555, 5'd31, 8'h00);
        for (int c = int'(CMD_BIN) + 1; c < CMD_CODES; c++)
            add_request(3'(c), 2'd1, 5'd6, 16'h1234, 5'd16, 8'h41);
        // column zero and lines other than the top one
        add_request(CMD_CHAR, 2'd1, 5'd0, 16'h0000, 5'd0, 8'h41);
        add_request(CMD_CHAR, 2'd2, 5'd0, 16'h0000, 5'd0, 8'h42);
        add_request(CMD_HEX, 2'd0, 5'd31, 16'h00F0, 5'd2, 8'h00);
        add_request(CMD_BIN, 2'd3, 5'd31, 16'h0003, 5'd2, 8'h00);
        directed_items = requests_pending.size();

        // random part: mostly well-formed requests, the rest raw field noise
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                item.command     = 3'($urandom_range(CMD_CHAR, CMD_BIN));
                item.line        = 2'($urandom_range(1, 2));
                item.column      = 5'($urandom_range(1, 16));
                item.digit_count = ($urandom_range(0, 9) == 0) ? 5'(MAX_DIGITS)
                                                               : 5'($urandom_range(0, 8));
                vsel             = $urandom_range(0, 7);
                if (vsel == 0)
                    item.value = 16'h0000;
                else if (vsel == 1)
                    item.value = 16'hFFFF;
                else if (vsel == 2)
                    item.value = 16'h8000;
                else if (vsel == 3)
                    item.value = 16'($urandom_range(0, 99));
                else
                    item.value = 16'($urandom);
                item.char_code = 8'($urandom);
            end
            else
            begin
                item.command     = 3'($urandom);
                item.line        = 2'($urandom);
                item.column      = 5'($urandom);
                item.value       = 16'($urandom);
                item.digit_count = 5'($urandom);
                item.char_code   = 8'($urandom);
            end
            requests_pending.push_back(item);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // all requests sent, then all writes seen, then a quiet tail
        while (requests_pending.size() > 0 || start)
            @(posedge clk);
        while (bus_writes_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d directed), %0d bus writes checked, %0d mismatches",
                 requests_sent, directed_items, writes_checked, errors);
        $display("per command: char %0d udec %0d sdec %0d hex %0d bin %0d unknown %0d",
                 cmd_seen[CMD_CHAR], cmd_seen[CMD_UDEC], cmd_seen[CMD_SDEC],
                 cmd_seen[CMD_HEX], cmd_seen[CMD_BIN],
                 cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
